/* rtl/spsf_pkg.sv */
// Shared types and constants for the span sprite pixel fetch block.
// Used by the channel interfaces, the result queue and the top level.
package spsf_pkg;

   localparam int ROW_W        = 10;
   localparam int SPAN_ROWS    = 1 << ROW_W;
   localparam int COORD_W      = 16;
   localparam int PIX_ADDR_W   = 16;
   localparam int PIXEL_BYTES  = 1 << PIX_ADDR_W;
   localparam int PAL_IDX_W    = 8;
   localparam int PAL_DEPTH    = 1 << PAL_IDX_W;
   localparam int COLOR_W      = 8;
   localparam int SPAN_W       = 3 * COORD_W;
   localparam int HEIGHT_W     = 11;
   localparam int SIZE_W       = PIX_ADDR_W + 1;
   localparam int CSR_IDX_W    = 2;

   localparam int FIFO_PTR_W   = 3;
   localparam int FIFO_DEPTH   = 1 << FIFO_PTR_W;
   localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

   localparam logic [COORD_W-1:0]    EMPTY_MARK     = 16'hFFFF;
   localparam logic [COLOR_W-1:0]    OPAQUE         = 8'hFF;
   localparam logic [SIZE_W-1:0]     PIX_LIMIT      = SIZE_W'(PIXEL_BYTES);
   localparam logic [FIFO_CNT_W-1:0] FIFO_FULL_CNT  = FIFO_CNT_W'(FIFO_DEPTH);

   typedef enum logic [1:0] {
      OP_SPAN_LOAD,
      OP_BYTE_LOAD,
      OP_PAL_LOAD,
      OP_PIXEL_READ
   } spsf_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMG_WIDTH,
      CSR_IMG_HEIGHT,
      CSR_PIXEL_DATA_SIZE
   } spsf_csr_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic [COLOR_W-1:0] alpha_out;
      logic               outside;
   } spsf_result_type;

   typedef struct packed {
      logic                  empty;
      logic                  full;
      logic [FIFO_CNT_W-1:0] count;
   } spsf_fifo_status_type;

endpackage

/* rtl/spsf_req_if.sv */
// Request channel of the span sprite pixel fetch block: valid/ready plus request fields.
// Depends on spsf_pkg for field widths.
interface spsf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            req_type;
   logic [spsf_pkg::ROW_W-1:0]            row;
   logic [spsf_pkg::COORD_W-1:0]          col;
   logic [spsf_pkg::COORD_W-1:0]          span_start;
   logic [spsf_pkg::COORD_W-1:0]          span_end;
   logic [spsf_pkg::COORD_W-1:0]          span_offset;
   logic [spsf_pkg::PIX_ADDR_W-1:0]       byte_addr;
   logic [spsf_pkg::PAL_IDX_W-1:0]        byte_value;
   logic [spsf_pkg::PAL_IDX_W-1:0]        pal_index;
   logic [spsf_pkg::COLOR_W-1:0]          red;
   logic [spsf_pkg::COLOR_W-1:0]          green;
   logic [spsf_pkg::COLOR_W-1:0]          blue;

   modport source (
      output valid, req_type, row, col, span_start, span_end, span_offset,
             byte_addr, byte_value, pal_index, red, green, blue,
      input  ready
   );
   modport sink (
      input  valid, req_type, row, col, span_start, span_end, span_offset,
             byte_addr, byte_value, pal_index, red, green, blue,
      output ready
   );
endinterface

/* rtl/spsf_rsp_if.sv */
// Response channel of the span sprite pixel fetch block: valid/ready plus pixel result.
// Depends on spsf_pkg for field widths.
interface spsf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spsf_pkg::COLOR_W-1:0] red_out;
   logic [spsf_pkg::COLOR_W-1:0] green_out;
   logic [spsf_pkg::COLOR_W-1:0] blue_out;
   logic [spsf_pkg::COLOR_W-1:0] alpha_out;
   logic                         outside;

   modport source (
      output valid, red_out, green_out, blue_out, alpha_out, outside,
      input  ready
   );
   modport sink (
      input  valid, red_out, green_out, blue_out, alpha_out, outside,
      output ready
   );
endinterface

/* rtl/spsf_csr_if.sv */
// Configuration write channel of the span sprite pixel fetch block.
// Depends on spsf_pkg for index and data widths.
interface spsf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [spsf_pkg::CSR_IDX_W-1:0]  index;
   logic [spsf_pkg::SIZE_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/spsf_rsp_fifo.sv */
// Result queue of the span sprite pixel fetch block: eight-entry register FIFO.
// Depends on spsf_pkg for the result and status types.
module spsf_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  spsf_pkg::spsf_result_type      push_data,
   input  logic                           pop,
   output spsf_pkg::spsf_result_type      head,
   output spsf_pkg::spsf_fifo_status_type status
);
   import spsf_pkg::*;

   spsf_result_type       fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign do_push = push && (count_ff != FIFO_FULL_CNT);
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = fifo_mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FIFO_FULL_CNT);
   assign status.count = count_ff;

endmodule

/* rtl/span_sprite_pixel_fetch.sv */
// Span sprite pixel fetch: span table -> pixel store -> palette lookup pipeline.
// A request transaction passes the pixel, palette and queue registers before response valid rises.
// Throughput: one request per cycle; ready drops while 8 transactions are outstanding,
// set by the eight-entry result queue.
// Reset clears configuration, stage valids and the queue; the memories hold garbage
// until written.
module span_sprite_pixel_fetch (
   input logic          clock,
   input logic          reset,
   spsf_req_if.sink     req_ch,
   spsf_rsp_if.source   rsp_ch,
   spsf_csr_if.sink     csr_ch
);
   import spsf_pkg::*;

   logic [COORD_W-1:0]    img_width_ff, img_width_in;
   logic [HEIGHT_W-1:0]   img_height_ff, img_height_in;
   logic [SIZE_W-1:0]     pix_size_ff, pix_size_in;

   logic [SPAN_W-1:0]     span_mem [SPAN_ROWS];
   logic [PAL_IDX_W-1:0]  pix_mem [PIXEL_BYTES];
   logic [3*COLOR_W-1:0]  pal_mem [PAL_DEPTH];

   logic [SPAN_W-1:0]     span_q_ff;
   logic [PAL_IDX_W-1:0]  pix_q_ff;
   logic [3*COLOR_W-1:0]  pal_q_ff;

   logic                  req_accept;
   logic                  csr_accept;
   spsf_op_type           req_op;
   logic                  req_outside;

   logic                  s1_valid_ff;
   spsf_op_type           s1_op_ff;
   logic [COORD_W-1:0]    s1_col_ff;
   logic                  s1_outside_ff;
   logic [PIX_ADDR_W-1:0] s1_byte_addr_ff;
   logic [PAL_IDX_W-1:0]  s1_byte_value_ff;
   logic [PAL_IDX_W-1:0]  s1_pal_index_ff;
   logic [3*COLOR_W-1:0]  s1_rgb_ff;

   logic                  s2_valid_ff;
   spsf_op_type           s2_op_ff;
   logic                  s2_hit_ff;
   logic                  s2_outside_ff;
   logic [PAL_IDX_W-1:0]  s2_pal_index_ff;
   logic [3*COLOR_W-1:0]  s2_rgb_ff;

   logic                  s3_valid_ff;
   logic                  s3_hit_ff;
   logic                  s3_outside_ff;

   logic [COORD_W-1:0]    span_s, span_e, span_off;
   logic [SIZE_W-1:0]     pix_limit;
   logic [SIZE_W-1:0]     pix_addr;
   logic                  span_cover;
   logic                  s1_hit;

   spsf_result_type       result;
   spsf_result_type       fifo_head;
   spsf_fifo_status_type  fifo_status;
   logic                  rsp_pop;

   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;

   // configuration
   assign csr_ch.ready = 1'b1;
   assign csr_accept   = csr_ch.valid && csr_ch.ready;

   always_comb begin
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      pix_size_in   = pix_size_ff;
      if (csr_accept) begin
         unique case (spsf_csr_type'(csr_ch.index))
            CSR_IMG_WIDTH:       img_width_in  = csr_ch.data[COORD_W-1:0];
            CSR_IMG_HEIGHT:      img_height_in = csr_ch.data[HEIGHT_W-1:0];
            CSR_PIXEL_DATA_SIZE: pix_size_in   = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= '0;
         img_height_ff <= '0;
         pix_size_ff   <= '0;
      end else begin
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         pix_size_ff   <= pix_size_in;
      end
   end

   // outstanding transaction count bounds the result queue
   assign req_ch.ready = (cnt_ff != FIFO_FULL_CNT);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_pop      = rsp_ch.valid && rsp_ch.ready;
   assign cnt_in       = cnt_ff + FIFO_CNT_W'(req_accept) - FIFO_CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // stage 0: span table access
   assign req_op      = spsf_op_type'(req_ch.req_type);
   assign req_outside = (req_ch.col >= img_width_ff)
                     || ({1'b0, req_ch.row} >= img_height_ff);

   always_ff @(posedge clock) begin
      if (req_accept && req_op == OP_SPAN_LOAD) begin
         span_mem[req_ch.row] <= {req_ch.span_start, req_ch.span_end, req_ch.span_offset};
      end else begin
         span_q_ff <= span_mem[req_ch.row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff         <= req_op;
      s1_col_ff        <= req_ch.col;
      s1_outside_ff    <= (req_op == OP_PIXEL_READ) && req_outside;
      s1_byte_addr_ff  <= req_ch.byte_addr;
      s1_byte_value_ff <= req_ch.byte_value;
      s1_pal_index_ff  <= req_ch.pal_index;
      s1_rgb_ff        <= {req_ch.red, req_ch.green, req_ch.blue};
   end

   // stage 1: span check and pixel store access
   assign span_s   = span_q_ff[SPAN_W-1 -: COORD_W];
   assign span_e   = span_q_ff[2*COORD_W-1 -: COORD_W];
   assign span_off = span_q_ff[COORD_W-1:0];

   assign pix_limit  = (pix_size_ff > PIX_LIMIT) ? PIX_LIMIT : pix_size_ff;
   assign pix_addr   = {1'b0, span_off} + {1'b0, s1_col_ff - span_s};
   assign span_cover = (span_s != EMPTY_MARK) && (span_s < img_width_ff)
                    && (span_e < img_width_ff) && (span_s <= span_e)
                    && (s1_col_ff >= span_s) && (s1_col_ff <= span_e);
   assign s1_hit     = (s1_op_ff == OP_PIXEL_READ) && !s1_outside_ff
                    && span_cover && (pix_addr < pix_limit);

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_op_ff == OP_BYTE_LOAD) begin
         pix_mem[s1_byte_addr_ff] <= s1_byte_value_ff;
      end else begin
         pix_q_ff <= pix_mem[pix_addr[PIX_ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff        <= s1_op_ff;
      s2_hit_ff       <= s1_hit;
      s2_outside_ff   <= s1_outside_ff;
      s2_pal_index_ff <= s1_pal_index_ff;
      s2_rgb_ff       <= s1_rgb_ff;
   end

   // stage 2: palette access
   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_op_ff == OP_PAL_LOAD) begin
         pal_mem[s2_pal_index_ff] <= s2_rgb_ff;
      end else begin
         pal_q_ff <= pal_mem[pix_q_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_hit_ff     <= s2_hit_ff;
      s3_outside_ff <= s2_outside_ff;
   end

   // stage 3: form result and queue it
   always_comb begin
      result = '0;
      if (s3_hit_ff) begin
         result.red_out   = pal_q_ff[3*COLOR_W-1 -: COLOR_W];
         result.green_out = pal_q_ff[2*COLOR_W-1 -: COLOR_W];
         result.blue_out  = pal_q_ff[COLOR_W-1:0];
         result.alpha_out = OPAQUE;
      end else begin
         result.outside   = s3_outside_ff;
      end
   end

   spsf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (result),
      .pop       (rsp_pop),
      .head      (fifo_head),
      .status    (fifo_status)
   );

   assign rsp_ch.valid     = !fifo_status.empty;
   assign rsp_ch.red_out   = fifo_head.red_out;
   assign rsp_ch.green_out = fifo_head.green_out;
   assign rsp_ch.blue_out  = fifo_head.blue_out;
   assign rsp_ch.alpha_out = fifo_head.alpha_out;
   assign rsp_ch.outside   = fifo_head.outside;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == FIFO_CNT_W'(s1_valid_ff) + FIFO_CNT_W'(s2_valid_ff)
              + FIFO_CNT_W'(s3_valid_ff) + fifo_status.count)
      else $error("outstanding count disagrees with pipeline and queue occupancy");

   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> !fifo_status.full)
      else $error("result pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_outside_ff) |=> (s2_valid_ff && !s2_hit_ff && s2_outside_ff))
      else $error("read outside the image marked opaque");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.alpha_out == '0)
                     || (rsp_ch.alpha_out == OPAQUE && !rsp_ch.outside)))
      else $error("inconsistent alpha and outside flag");

endmodule

/* bench/span_sprite_pixel_fetch_tb.sv */
// Self-checking bench for span_sprite_pixel_fetch: loads spans, pixel bytes and palette,
// reads pixels under several image settings and checks every response transaction.
// Depends on spsf_pkg and the spsf_req_if, spsf_rsp_if and spsf_csr_if interfaces.
module span_sprite_pixel_fetch_tb;
   import spsf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int IDLE_PCT     = 22;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      spsf_op_type           kind;
      logic [ROW_W-1:0]      row;
      logic [COORD_W-1:0]    col;
      logic [COORD_W-1:0]    span_start;
      logic [COORD_W-1:0]    span_end;
      logic [COORD_W-1:0]    span_offset;
      logic [PIX_ADDR_W-1:0] byte_addr;
      logic [PAL_IDX_W-1:0]  byte_value;
      logic [PAL_IDX_W-1:0]  pal_index;
      logic [COLOR_W-1:0]    red;
      logic [COLOR_W-1:0]    green;
      logic [COLOR_W-1:0]    blue;
   } pixel_request_type;

   class sprite_scoreboard_type;
      bit [COORD_W-1:0]   width;
      bit [HEIGHT_W-1:0]  height;
      bit [SIZE_W-1:0]    data_size;
      bit [COORD_W-1:0]   span_first  [SPAN_ROWS];
      bit [COORD_W-1:0]   span_last   [SPAN_ROWS];
      bit [COORD_W-1:0]   span_base   [SPAN_ROWS];
      bit                 span_loaded [SPAN_ROWS];
      bit [COLOR_W-1:0]   pixel_byte  [PIXEL_BYTES];
      bit                 byte_loaded [PIXEL_BYTES];
      bit [3*COLOR_W-1:0] palette     [PAL_DEPTH];
      bit                 color_loaded[PAL_DEPTH];
      spsf_result_type    pending_pixels[$];
      int unsigned        mismatch_count;

      function void set_reg(spsf_csr_type idx, bit [SIZE_W-1:0] value);
         case (idx)
            CSR_IMG_WIDTH:       width = value[COORD_W-1:0];
            CSR_IMG_HEIGHT:      height = value[HEIGHT_W-1:0];
            CSR_PIXEL_DATA_SIZE: data_size = value;
            default: ;
         endcase
      endfunction

      function int unsigned byte_limit();
         return (data_size > PIXEL_BYTES) ? PIXEL_BYTES : int'(data_size);
      endfunction

      function void locate(input bit [ROW_W-1:0] row, input bit [COORD_W-1:0] col,
                           output bit off_image, output bit covered,
                           output int unsigned addr);
         bit [COORD_W-1:0] s;
         bit [COORD_W-1:0] e;
         s = span_first[row];
         e = span_last[row];
         off_image = (col >= width) || (row >= height);
         addr = int'(span_base[row]) + int'(col) - int'(s);
         covered = !off_image && s != EMPTY_MARK && s < width && e < width && s <= e
                   && col >= s && col <= e && addr < byte_limit();
      endfunction

      function bit read_is_safe(bit [ROW_W-1:0] row, bit [COORD_W-1:0] col);
         bit off_image;
         bit covered;
         int unsigned addr;
         locate(row, col, off_image, covered, addr);
         if (off_image) return 1'b1;
         if (!span_loaded[row]) return 1'b0;
         return !covered || (byte_loaded[addr] && color_loaded[pixel_byte[addr]]);
      endfunction

      function void note_request(pixel_request_type r);
         spsf_result_type res;
         bit off_image;
         bit covered;
         int unsigned addr;
         res = '0;
         case (r.kind)
            OP_SPAN_LOAD: begin
               span_first[r.row] = r.span_start;
               span_last[r.row] = r.span_end;
               span_base[r.row] = r.span_offset;
               span_loaded[r.row] = 1'b1;
            end
            OP_BYTE_LOAD: begin
               pixel_byte[r.byte_addr] = r.byte_value;
               byte_loaded[r.byte_addr] = 1'b1;
            end
            OP_PAL_LOAD: begin
               palette[r.pal_index] = {r.red, r.green, r.blue};
               color_loaded[r.pal_index] = 1'b1;
            end
            default: begin
               locate(r.row, r.col, off_image, covered, addr);
               res.outside = off_image;
               if (covered) begin
                  {res.red_out, res.green_out, res.blue_out} = palette[pixel_byte[addr]];
                  res.alpha_out = OPAQUE;
               end
            end
         endcase
         pending_pixels.push_back(res);
      endfunction

      function void check_pixel(spsf_result_type got);
         spsf_result_type want;
         bit bad;
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: r=%0d g=%0d b=%0d a=%0d outside=%0d",
                        got.red_out, got.green_out, got.blue_out, got.alpha_out, got.outside);
            return;
         end
         want = pending_pixels.pop_front();
         bad = (got.red_out !== want.red_out) || (got.green_out !== want.green_out)
               || (got.blue_out !== want.blue_out) || (got.alpha_out !== want.alpha_out)
               || (got.outside !== want.outside);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d outside=%0d, %s",
                        want.red_out, want.green_out, want.blue_out, want.alpha_out,
                        want.outside,
                        $sformatf("got r=%0d g=%0d b=%0d a=%0d outside=%0d",
                                  got.red_out, got.green_out, got.blue_out,
                                  got.alpha_out, got.outside));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   bit                    quiet = 1'b0;
   int unsigned           cycle_count = 0;
   sprite_scoreboard_type sb = new();

   spsf_req_if req_ch();
   spsf_rsp_if rsp_ch();
   spsf_csr_if csr_ch();

   span_sprite_pixel_fetch uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_side
      spsf_result_type got;
      got = {rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out, rsp_ch.alpha_out,
             rsp_ch.outside};
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_pixel(got);
      rsp_ch.ready <= !reset && (quiet || $urandom_range(99) >= IDLE_PCT);
   end

   function automatic pixel_request_type scrambled_request(spsf_op_type kind);
      pixel_request_type r;
      r.kind        = kind;
      r.row         = ROW_W'($urandom);
      r.col         = COORD_W'($urandom);
      r.span_start  = COORD_W'($urandom);
      r.span_end    = COORD_W'($urandom);
      r.span_offset = COORD_W'($urandom);
      r.byte_addr   = PIX_ADDR_W'($urandom);
      r.byte_value  = PAL_IDX_W'($urandom);
      r.pal_index   = PAL_IDX_W'($urandom);
      r.red         = COLOR_W'($urandom);
      r.green       = COLOR_W'($urandom);
      r.blue        = COLOR_W'($urandom);
      return r;
   endfunction

   function automatic pixel_request_type make_span(int unsigned row, int unsigned s,
                                                   int unsigned e, int unsigned off);
      pixel_request_type r;
      r = scrambled_request(OP_SPAN_LOAD);
      r.row = ROW_W'(row);
      r.span_start = COORD_W'(s);
      r.span_end = COORD_W'(e);
      r.span_offset = COORD_W'(off);
      return r;
   endfunction

   function automatic pixel_request_type make_byte(int unsigned addr, int unsigned value);
      pixel_request_type r;
      r = scrambled_request(OP_BYTE_LOAD);
      r.byte_addr = PIX_ADDR_W'(addr);
      r.byte_value = PAL_IDX_W'(value);
      return r;
   endfunction

   function automatic pixel_request_type make_pal(int unsigned idx, int unsigned red,
                                                  int unsigned green, int unsigned blue);
      pixel_request_type r;
      r = scrambled_request(OP_PAL_LOAD);
      r.pal_index = PAL_IDX_W'(idx);
      r.red = COLOR_W'(red);
      r.green = COLOR_W'(green);
      r.blue = COLOR_W'(blue);
      return r;
   endfunction

   function automatic pixel_request_type make_read(int unsigned row, int unsigned col);
      pixel_request_type r;
      r = scrambled_request(OP_PIXEL_READ);
      r.row = ROW_W'(row);
      r.col = COORD_W'(col);
      return r;
   endfunction

   // Mostly well-formed spans inside the current width, some empty rows, some noise.
   function automatic pixel_request_type span_for_row(bit [ROW_W-1:0] row);
      pixel_request_type r;
      int unsigned pick;
      int unsigned last;
      int unsigned s;
      int unsigned e;
      int unsigned off;
      r = scrambled_request(OP_SPAN_LOAD);
      r.row = row;
      pick = $urandom_range(19);
      if (pick < 15 && sb.width != 0) begin
         last = sb.width - 1;
         s = $urandom_range(last, 0);
         e = $urandom_range((s + 48 > last) ? last : s + 48, s);
         off = $urandom_range(sb.byte_limit(), 0);
         r.span_start = COORD_W'(s);
         r.span_end = COORD_W'(e);
         r.span_offset = COORD_W'((off > 65535) ? 65535 : off);
      end else if (pick < 17) begin
         r.span_start = EMPTY_MARK;
      end
      return r;
   endfunction

   task automatic send_request(input pixel_request_type r);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.req_type    <= r.kind;
      req_ch.row         <= r.row;
      req_ch.col         <= r.col;
      req_ch.span_start  <= r.span_start;
      req_ch.span_end    <= r.span_end;
      req_ch.span_offset <= r.span_offset;
      req_ch.byte_addr   <= r.byte_addr;
      req_ch.byte_value  <= r.byte_value;
      req_ch.pal_index   <= r.pal_index;
      req_ch.red         <= r.red;
      req_ch.green       <= r.green;
      req_ch.blue        <= r.blue;
      req_ch.valid       <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic write_reg(input spsf_csr_type idx, input int unsigned value);
      csr_ch.index <= idx;
      csr_ch.data  <= SIZE_W'(value);
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      sb.set_reg(idx, SIZE_W'(value));
      @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_transaction();
      pixel_request_type r;
      int unsigned pick;
      int unsigned rows_lim;
      int unsigned win;
      bit off_image;
      bit covered;
      int unsigned addr;
      pick = $urandom_range(99);
      rows_lim = (sb.height == 0) ? 1 : ((sb.height > SPAN_ROWS) ? SPAN_ROWS : sb.height);
      win = sb.byte_limit() + 32;
      if (win > PIXEL_BYTES) win = PIXEL_BYTES;
      if (pick < 15) begin
         r = span_for_row(ROW_W'($urandom));
         if ($urandom_range(4) != 0) r.row = ROW_W'($urandom_range(rows_lim - 1, 0));
         send_request(r);
      end else if (pick < 35) begin
         r = scrambled_request(OP_BYTE_LOAD);
         if ($urandom_range(6) != 0) r.byte_addr = PIX_ADDR_W'($urandom_range(win - 1, 0));
         send_request(r);
      end else if (pick < 42) begin
         send_request(scrambled_request(OP_PAL_LOAD));
      end else begin
         r = scrambled_request(OP_PIXEL_READ);
         if ($urandom_range(9) != 0) r.row = ROW_W'($urandom_range(rows_lim - 1, 0));
         // load whatever the read will touch first
         if (!sb.span_loaded[r.row]) send_request(span_for_row(r.row));
         pick = $urandom_range(9);
         if (pick < 7)
            r.col = COORD_W'($urandom_range(sb.span_first[r.row], sb.span_last[r.row]));
         else if (pick < 9)
            r.col = COORD_W'($urandom_range(sb.width, 0));
         sb.locate(r.row, r.col, off_image, covered, addr);
         if (covered && !sb.byte_loaded[addr]) begin
            send_request(make_byte(addr, $urandom_range(255)));
         end
         if (!sb.read_is_safe(r.row, r.col)) r.col = EMPTY_MARK;
         send_request(r);
      end
   endtask

   task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned s,
                            input int unsigned count, input bit no_idle);
      settle();
      write_reg(CSR_IMG_WIDTH, w);
      write_reg(CSR_IMG_HEIGHT, h);
      write_reg(CSR_PIXEL_DATA_SIZE, s);
      quiet = no_idle;
      repeat (count) random_transaction();
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.req_type    = '0;
      req_ch.row         = '0;
      req_ch.col         = '0;
      req_ch.span_start  = '0;
      req_ch.span_end    = '0;
      req_ch.span_offset = '0;
      req_ch.byte_addr   = '0;
      req_ch.byte_value  = '0;
      req_ch.pal_index   = '0;
      req_ch.red         = '0;
      req_ch.green       = '0;
      req_ch.blue        = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      run_phase(65535, 1024, 65536, 0, 1'b0);
      send_request(make_pal(0, 8'h12, 8'h34, 8'h56));
      send_request(make_pal(255, 255, 255, 255));
      send_request(make_pal(8'hA5, 8'hA5, 8'h5A, 8'hC3));
      send_request(make_byte(0, 255));
      send_request(make_byte(65535, 0));
      send_request(make_byte(65534, 8'hA5));
      send_request(make_span(0, 0, 65534, 0));
      send_request(make_span(1, 10, 5, 0));
      send_request(make_span(2, 0, 65535, 0));
      send_request(make_span(3, 1, 3, 65534));
      send_request(make_span(1023, EMPTY_MARK, 0, 0));
      send_request(make_read(0, 0));
      send_request(make_read(0, 65534));
      send_request(make_read(0, 65535));
      send_request(make_read(1023, 5));
      send_request(make_read(1, 7));
      send_request(make_read(2, 0));
      send_request(make_read(3, 0));
      send_request(make_read(3, 1));
      send_request(make_read(3, 2));
      send_request(make_read(3, 3));

      for (int i = 0; i < PAL_DEPTH; i++)
         send_request(make_pal(i, $urandom_range(255), $urandom_range(255), $urandom_range(255)));

      run_phase(96, 40, 2048, 80, 1'b0);
      run_phase(0, 0, 0, 30, 1'b0);
      run_phase(300, 1024, 0, 50, 1'b0);
      run_phase(1, 1, 1, 40, 1'b0);
      run_phase(65535, 1023, 65535, 80, 1'b0);
      run_phase($urandom_range(4000, 1), $urandom_range(1024, 1), $urandom_range(65536, 0),
                80, 1'b0);
      run_phase(160, 64, 8192, 130, 1'b1);
      run_phase(640, 480, 65536, 80, 1'b0);
      settle();

      if (sb.mismatch_count == 0 && sb.pending_pixels.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

/* span_sprite_pixel_fetch.f */
rtl/spsf_pkg.sv
rtl/spsf_req_if.sv
rtl/spsf_rsp_if.sv
rtl/spsf_csr_if.sv
rtl/spsf_rsp_fifo.sv
rtl/span_sprite_pixel_fetch.sv
bench/span_sprite_pixel_fetch_tb.sv
